@@ sv/gpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gpa_pkg;

  // Default table geometry and value width.
  localparam int GPA_GOAL_SLOTS = 8;
  localparam int GPA_MAX_DIMS   = 4;
  localparam int GPA_VALUE_BITS = 32;

  // Priorities are unsigned Q1.16 with full scale 1.0 held as 65536.
  localparam int          PRIO_W    = 17;
  localparam logic [16:0] PRIO_FULL = 17'd65536;

  // Status codes returned with every transaction.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_WRITE_DIM  = 3'd0,
    OP_APPEND     = 3'd1,
    OP_SET_PRIO   = 3'd2,
    OP_SELECT     = 3'd3,
    OP_WRITE_MEAS = 3'd4,
    OP_ARBITRATE  = 3'd5
  } gpa_op_e;

endpackage

`default_nettype wire

@@ sv/gpa_goal_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Target and tolerance store: one write port, one read port, registered read data.
module gpa_goal_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 64
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Synchronous read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/gpa_tol_check.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Checks one dimension: the absolute error must not exceed the tolerance.
module gpa_tol_check #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic signed [VALUE_BITS-1:0] meas_i,
  input  wire logic signed [VALUE_BITS-1:0] target_i,
  input  wire logic signed [VALUE_BITS-1:0] tol_i,
  output logic                              within_o
);

  logic signed [VALUE_BITS+1:0] diff;
  logic signed [VALUE_BITS+1:0] mag;
  logic signed [VALUE_BITS+1:0] tol_x;

  // Two guard bits keep the difference and its magnitude exact.
  always_comb begin
    diff  = (VALUE_BITS+2)'(meas_i) - (VALUE_BITS+2)'(target_i);
    mag   = diff[VALUE_BITS+1] ? -diff : diff;
    tol_x = (VALUE_BITS+2)'(tol_i);
    // A negative tolerance can never be met.
    within_o = !tol_i[VALUE_BITS-1] && (mag <= tol_x);
  end

endmodule

`default_nettype wire

@@ sv/goal_priority_arbiter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Goal priority arbiter. Each transaction carries one operation (write a goal's
// target and tolerance, append a goal, set a priority, select a goal, write a
// measurement or arbitrate) and returns exactly one result. All operations except
// arbitrate return their result in the cycle after acceptance, and a new transaction
// can be taken at the same edge as the result is taken, so they run at one per
// cycle while the consumer does not stall. Arbitrate walks the goal table through
// the single read port of the target and tolerance memory, one dimension check per
// cycle over every dimension of every appended goal (a goal with no dimensions
// taking one check), then passes the drain and commit states before its result
// appears. Arbitrate with an empty table answers like the other operations.
// Entries of the target and tolerance store must be written before an
// arbitration reads them; no clearing pass is run after reset.
module goal_priority_arbiter
  import gpa_pkg::*;
#(
  parameter int GOAL_SLOTS = GPA_GOAL_SLOTS,
  parameter int MAX_DIMS   = GPA_MAX_DIMS,
  parameter int VALUE_BITS = GPA_VALUE_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic        [2:0]  op_i,
  input  wire logic        [2:0]  goal_index_i,
  input  wire logic        [1:0]  dim_index_i,
  input  wire logic signed [31:0] target_value_i,
  input  wire logic signed [31:0] tolerance_value_i,
  input  wire logic        [2:0]  dim_count_i,
  input  wire logic signed [17:0] priority_value_i,
  input  wire logic signed [31:0] measured_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    status_o,
  output logic             [2:0]  lead_goal_o,
  output logic                    has_active_o,
  output logic             [31:0] switch_count_o,
  output logic             [7:0]  achieved_mask_o,
  output logic             [3:0]  goal_count_o,
  output logic                    reference_update_o
);

  localparam int GOAL_W = (GOAL_SLOTS > 1) ? $clog2(GOAL_SLOTS) : 1;
  localparam int CNT_W  = $clog2(GOAL_SLOTS + 1);
  localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DCNT_W = $clog2(MAX_DIMS + 1);
  localparam int DEPTH  = GOAL_SLOTS * MAX_DIMS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW     = 2 * VALUE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  // Control and architectural state.
  state_e                         state_q, state_d;
  logic                           out_valid_q, out_valid_d;
  logic                           status_q, status_d;
  logic                           ref_upd_q, ref_upd_d;
  logic        [CNT_W-1:0]        appended_q, appended_d;
  logic        [GOAL_W-1:0]       current_q, current_d;
  logic                           cur_valid_q, cur_valid_d;
  logic        [31:0]             switch_q, switch_d;
  logic        [GOAL_SLOTS-1:0]   achieved_q, achieved_d;
  logic        [DCNT_W-1:0]       dims_q [GOAL_SLOTS];
  logic        [DCNT_W-1:0]       dims_d [GOAL_SLOTS];
  logic        [PRIO_W-1:0]       prio_q [GOAL_SLOTS];
  logic        [PRIO_W-1:0]       prio_d [GOAL_SLOTS];
  logic signed [VALUE_BITS-1:0]   meas_q [MAX_DIMS];
  logic signed [VALUE_BITS-1:0]   meas_d [MAX_DIMS];

  // Arbitration walk: issue stage counters.
  logic        [GOAL_W-1:0]       walk_g_q, walk_g_d;
  logic        [DIM_W-1:0]        walk_d_q, walk_d_d;

  // Arbitration walk: check stage, aligned with the memory read data.
  logic                           chk_valid_q, chk_valid_d;
  logic        [GOAL_W-1:0]       chk_g_q, chk_g_d;
  logic        [DIM_W-1:0]        chk_d_q, chk_d_d;
  logic                           chk_first_q, chk_first_d;
  logic                           chk_last_q, chk_last_d;
  logic                           chk_has_q, chk_has_d;
  logic                           met_acc_q, met_acc_d;
  logic        [GOAL_SLOTS-1:0]   mask_acc_q, mask_acc_d;
  logic                           found_q, found_d;
  logic        [GOAL_W-1:0]       best_q, best_d;
  logic        [PRIO_W-1:0]       best_p_q, best_p_d;

  // Memory ports and combinational helpers.
  logic                           mem_we;
  logic        [AW-1:0]           mem_waddr;
  logic        [DW-1:0]           mem_wdata;
  logic        [AW-1:0]           mem_raddr;
  logic        [DW-1:0]           mem_rdata;
  logic                           dim_ok;
  logic                           in_accept;
  logic        [DCNT_W-1:0]       walk_n;
  logic                           walk_last;
  logic                           met_now;
  logic        [GOAL_W-1:0]       gi;
  logic        [DIM_W-1:0]        di;

  gpa_goal_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_goal_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  gpa_tol_check #(
    .VALUE_BITS (VALUE_BITS)
  ) u_tol_check (
    .meas_i   (meas_q[chk_d_q]),
    .target_i (mem_rdata[DW-1:VALUE_BITS]),
    .tol_i    (mem_rdata[VALUE_BITS-1:0]),
    .within_o (dim_ok)
  );

  // Handshake: one transaction at a time, taken once the result register frees.
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Indices narrowed to the table geometry; only used after a range check.
  assign gi = GOAL_W'(goal_index_i);
  assign di = DIM_W'(dim_index_i);

  // Issue stage: address of the next dimension to check.
  assign walk_n    = dims_q[walk_g_q];
  assign walk_last = (walk_n == '0) || ((DCNT_W'(walk_d_q) + DCNT_W'(1)) == walk_n);
  assign mem_raddr = AW'(int'(walk_g_q) * MAX_DIMS + int'(walk_d_q));

  // Check stage: running verdict for the goal under test.
  assign met_now = (chk_first_q || met_acc_q) && (!chk_has_q || dim_ok);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    ref_upd_d   = ref_upd_q;
    appended_d  = appended_q;
    current_d   = current_q;
    cur_valid_d = cur_valid_q;
    switch_d    = switch_q;
    achieved_d  = achieved_q;
    dims_d      = dims_q;
    prio_d      = prio_q;
    meas_d      = meas_q;
    walk_g_d    = walk_g_q;
    walk_d_d    = walk_d_q;
    chk_valid_d = 1'b0;
    chk_g_d     = walk_g_q;
    chk_d_d     = walk_d_q;
    chk_first_d = (walk_d_q == '0);
    chk_last_d  = walk_last;
    chk_has_d   = (walk_n != '0);
    met_acc_d   = met_acc_q;
    mask_acc_d  = mask_acc_q;
    found_d     = found_q;
    best_d      = best_q;
    best_p_d    = best_p_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(int'(gi) * MAX_DIMS + int'(di));
    mem_wdata   = {VALUE_BITS'(target_value_i), VALUE_BITS'(tolerance_value_i)};

    // Result register empties when the consumer takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          out_valid_d = 1'b1;
          status_d    = STATUS_OK;
          ref_upd_d   = 1'b0;
          unique case (op_i)
            OP_WRITE_DIM: begin
              if (32'(goal_index_i) >= GOAL_SLOTS || 32'(dim_index_i) >= MAX_DIMS) begin
                status_d = STATUS_REJECT;
              end else begin
                mem_we = 1'b1;
              end
            end
            OP_APPEND: begin
              if (32'(appended_q) >= GOAL_SLOTS || 32'(dim_count_i) > MAX_DIMS) begin
                status_d = STATUS_REJECT;
              end else begin
                dims_d[appended_q[GOAL_W-1:0]] = DCNT_W'(dim_count_i);
                prio_d[appended_q[GOAL_W-1:0]] = PRIO_FULL;
                appended_d = appended_q + CNT_W'(1);
                // The first goal becomes active without counting a switch.
                if (appended_q == '0) begin
                  current_d   = '0;
                  cur_valid_d = 1'b1;
                end
              end
            end
            OP_SET_PRIO: begin
              if (32'(goal_index_i) >= 32'(appended_q)) begin
                status_d = STATUS_REJECT;
              end else if (priority_value_i[17]) begin
                prio_d[gi] = '0;
              end else if (priority_value_i > $signed({1'b0, PRIO_FULL})) begin
                prio_d[gi] = PRIO_FULL;
              end else begin
                prio_d[gi] = priority_value_i[PRIO_W-1:0];
              end
            end
            OP_SELECT: begin
              if (32'(goal_index_i) >= 32'(appended_q)) begin
                status_d = STATUS_REJECT;
              end else begin
                current_d   = gi;
                cur_valid_d = 1'b1;
                switch_d    = switch_q + 32'd1;
              end
            end
            OP_WRITE_MEAS: begin
              if (32'(dim_index_i) >= MAX_DIMS) begin
                status_d = STATUS_REJECT;
              end else begin
                meas_d[di] = VALUE_BITS'(measured_value_i);
              end
            end
            OP_ARBITRATE: begin
              // An empty table answers at once with no change.
              if (appended_q != '0) begin
                out_valid_d = 1'b0;
                state_d     = ST_WALK;
                walk_g_d    = '0;
                walk_d_d    = '0;
                mask_acc_d  = '0;
                found_d     = 1'b0;
              end
            end
            default: begin
              status_d = STATUS_REJECT;
            end
          endcase
        end
      end

      ST_WALK: begin
        // One dimension read is issued per cycle.
        chk_valid_d = 1'b1;
        if (walk_last) begin
          walk_d_d = '0;
          if ((CNT_W'(walk_g_q) + CNT_W'(1)) == appended_q) begin
            state_d = ST_DRAIN;
          end else begin
            walk_g_d = walk_g_q + GOAL_W'(1);
          end
        end else begin
          walk_d_d = walk_d_q + DIM_W'(1);
        end
      end

      ST_DRAIN: begin
        // The final check completes in this cycle.
        state_d = ST_COMMIT;
      end

      ST_COMMIT: begin
        achieved_d  = mask_acc_q;
        out_valid_d = 1'b1;
        status_d    = STATUS_OK;
        ref_upd_d   = found_q;
        if (found_q && (!cur_valid_q || current_q != best_q)) begin
          current_d   = best_q;
          cur_valid_d = 1'b1;
          switch_d    = switch_q + 32'd1;
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Check stage: fold each dimension into the goal verdict; mark a met goal, rank an unmet one.
    if (chk_valid_q) begin
      met_acc_d = met_now;
      if (chk_last_q) begin
        if (met_now) begin
          mask_acc_d[chk_g_q] = 1'b1;
        end else if (!found_q || prio_q[chk_g_q] > best_p_q) begin
          found_d  = 1'b1;
          best_d   = chk_g_q;
          best_p_d = prio_q[chk_g_q];
        end
      end
    end
  end

  // State, control and table registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      ref_upd_q   <= 1'b0;
      appended_q  <= '0;
      current_q   <= '0;
      cur_valid_q <= 1'b0;
      switch_q    <= '0;
      achieved_q  <= '0;
      for (int i = 0; i < GOAL_SLOTS; i++) begin
        dims_q[i] <= '0;
        prio_q[i] <= '0;
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
        meas_q[i] <= '0;
      end
      walk_g_q    <= '0;
      walk_d_q    <= '0;
      chk_valid_q <= 1'b0;
      mask_acc_q  <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      ref_upd_q   <= ref_upd_d;
      appended_q  <= appended_d;
      current_q   <= current_d;
      cur_valid_q <= cur_valid_d;
      switch_q    <= switch_d;
      achieved_q  <= achieved_d;
      dims_q      <= dims_d;
      prio_q      <= prio_d;
      meas_q      <= meas_d;
      walk_g_q    <= walk_g_d;
      walk_d_q    <= walk_d_d;
      chk_valid_q <= chk_valid_d;
      mask_acc_q  <= mask_acc_d;
      found_q     <= found_d;
    end
  end

  // Check stage payload needs no reset.
  always_ff @(posedge clk_i) begin
    chk_g_q     <= chk_g_d;
    chk_d_q     <= chk_d_d;
    chk_first_q <= chk_first_d;
    chk_last_q  <= chk_last_d;
    chk_has_q   <= chk_has_d;
    met_acc_q   <= met_acc_d;
    best_q      <= best_d;
    best_p_q    <= best_p_d;
  end

  // Result fields are read straight from the state, which holds while stalled.
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign lead_goal_o        = 3'(current_q);
  assign has_active_o       = cur_valid_q;
  assign switch_count_o     = switch_q;
  assign achieved_mask_o    = 8'(achieved_q);
  assign goal_count_o       = 4'(appended_q);
  assign reference_update_o = ref_upd_q;

endmodule

`default_nettype wire

@@ tb/tb_goal_priority_arbiter.sv @@
`timescale 1ns / 1ps

module tb_goal_priority_arbiter;
  import gpa_pkg::*;

  // Opcodes that the block does not define; both must be rejected.
  localparam logic [2:0] OP_RESERVED_LO = 3'd6;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;

  localparam int TABLE_SLOTS  = GPA_GOAL_SLOTS * GPA_MAX_DIMS;
  localparam int DRAIN_CYCLES = TABLE_SLOTS + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 150;

  // One transaction towards the block.
  typedef struct packed {
    logic        [2:0]  op;
    logic        [2:0]  goal_index;
    logic        [1:0]  dim_index;
    logic signed [31:0] target_value;
    logic signed [31:0] tolerance_value;
    logic        [2:0]  dim_count;
    logic signed [17:0] priority_value;
    logic signed [31:0] measured_value;
  } goal_cmd_t;

  // One result from the block.
  typedef struct packed {
    logic        status;
    logic [2:0]  lead_goal;
    logic        has_active;
    logic [31:0] switch_count;
    logic [7:0]  achieved_mask;
    logic [3:0]  goal_count;
    logic        reference_update;
  } goal_status_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic        [2:0]  op_i = '0;
  logic        [2:0]  goal_index_i = '0;
  logic        [1:0]  dim_index_i = '0;
  logic signed [31:0] target_value_i = '0;
  logic signed [31:0] tolerance_value_i = '0;
  logic        [2:0]  dim_count_i = '0;
  logic signed [17:0] priority_value_i = '0;
  logic signed [31:0] measured_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               status_o;
  logic        [2:0]  lead_goal_o;
  logic               has_active_o;
  logic        [31:0] switch_count_o;
  logic        [7:0]  achieved_mask_o;
  logic        [3:0]  goal_count_o;
  logic               reference_update_o;

  goal_priority_arbiter dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .goal_index_i       (goal_index_i),
    .dim_index_i        (dim_index_i),
    .target_value_i     (target_value_i),
    .tolerance_value_i  (tolerance_value_i),
    .dim_count_i        (dim_count_i),
    .priority_value_i   (priority_value_i),
    .measured_value_i   (measured_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .lead_goal_o        (lead_goal_o),
    .has_active_o       (has_active_o),
    .switch_count_o     (switch_count_o),
    .achieved_mask_o    (achieved_mask_o),
    .goal_count_o       (goal_count_o),
    .reference_update_o (reference_update_o)
  );

  // Shadow copy of the goal table and arbitration state.
  longint       goal_target [TABLE_SLOTS];
  longint       goal_tolerance [TABLE_SLOTS];
  bit           entry_written [TABLE_SLOTS];
  int           goal_dims [GPA_GOAL_SLOTS];
  int           goal_prio [GPA_GOAL_SLOTS];
  longint       measurement [GPA_MAX_DIMS];
  int           goal_total = 0;
  logic [2:0]   active_idx = '0;
  logic         active_valid = 1'b0;
  logic [31:0]  switch_total = '0;
  logic [7:0]   met_mask = '0;

  goal_status_t pending_status[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_cycles_req = 0;
  int           hold_left = 0;
  int unsigned  cycle_count = 0;

  // Free-running clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A goal is met when every one of its dimensions lies within tolerance.
  function automatic bit goal_reached(int g);
    longint err;
    for (int d = 0; d < goal_dims[g] && d < GPA_MAX_DIMS; d++) begin
      err = measurement[d] - goal_target[g * GPA_MAX_DIMS + d];
      if (err < 0) err = -err;
      if (err > goal_tolerance[g * GPA_MAX_DIMS + d]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one accepted transaction to the shadow state and return the result.
  function automatic goal_status_t apply_goal_cmd(goal_cmd_t c);
    goal_status_t r;
    int           slot;
    int           best;
    int           best_prio;
    int           p;
    bit           found;
    logic [7:0]   mask;
    r.status = STATUS_OK;
    r.reference_update = 1'b0;
    case (c.op)
      OP_WRITE_DIM: begin
        if (c.goal_index >= GPA_GOAL_SLOTS || c.dim_index >= GPA_MAX_DIMS) begin
          r.status = STATUS_REJECT;
        end else begin
          slot = c.goal_index * GPA_MAX_DIMS + c.dim_index;
          goal_target[slot] = $signed(c.target_value);
          goal_tolerance[slot] = $signed(c.tolerance_value);
          entry_written[slot] = 1'b1;
        end
      end
      OP_APPEND: begin
        if (goal_total >= GPA_GOAL_SLOTS || c.dim_count > GPA_MAX_DIMS) begin
          r.status = STATUS_REJECT;
        end else begin
          goal_dims[goal_total] = c.dim_count;
          goal_prio[goal_total] = PRIO_FULL;
          goal_total++;
          // The first goal becomes active without counting a switch.
          if (goal_total == 1) begin
            active_idx = '0;
            active_valid = 1'b1;
          end
        end
      end
      OP_SET_PRIO: begin
        if (c.goal_index >= goal_total) begin
          r.status = STATUS_REJECT;
        end else begin
          p = $signed(c.priority_value);
          if (p < 0) p = 0;
          if (p > PRIO_FULL) p = PRIO_FULL;
          goal_prio[c.goal_index] = p;
        end
      end
      OP_SELECT: begin
        if (c.goal_index >= goal_total) begin
          r.status = STATUS_REJECT;
        end else begin
          active_idx = c.goal_index;
          active_valid = 1'b1;
          switch_total++;
        end
      end
      OP_WRITE_MEAS: begin
        if (c.dim_index >= GPA_MAX_DIMS) r.status = STATUS_REJECT;
        else measurement[c.dim_index] = $signed(c.measured_value);
      end
      OP_ARBITRATE: begin
        if (goal_total > 0) begin
          best = 0;
          best_prio = -1;
          found = 1'b0;
          mask = '0;
          // Highest priority among the unmet goals, lowest index on a tie.
          for (int g = 0; g < goal_total; g++) begin
            if (goal_reached(g)) begin
              mask[g] = 1'b1;
            end else if (goal_prio[g] > best_prio) begin
              best_prio = goal_prio[g];
              best = g;
              found = 1'b1;
            end
          end
          met_mask = mask;
          if (found) begin
            if (!active_valid || active_idx != 3'(best)) begin
              active_idx = 3'(best);
              active_valid = 1'b1;
              switch_total++;
            end
            r.reference_update = 1'b1;
          end
        end
      end
      default: r.status = STATUS_REJECT;
    endcase
    r.lead_goal = active_idx;
    r.has_active = active_valid;
    r.switch_count = switch_total;
    r.achieved_mask = met_mask;
    r.goal_count = 4'(goal_total);
    return r;
  endfunction

  // Finds a table entry that an arbitration would read before it was written.
  function automatic bit find_unwritten(output int slot);
    slot = 0;
    for (int g = 0; g < goal_total; g++) begin
      for (int d = 0; d < goal_dims[g]; d++) begin
        if (!entry_written[g * GPA_MAX_DIMS + d]) begin
          slot = g * GPA_MAX_DIMS + d;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Values cluster around a few whole numbers so that goals are often met.
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return (int'($urandom_range(6)) - 3) * 65536 + int'($urandom_range(4095)) - 2048;
    if (sel < 75) return $urandom;
    if (sel < 85) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return int'($urandom_range(8191)) - 4096;
  endfunction

  function automatic logic signed [31:0] pick_tolerance();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom_range(3 * 65536);
    if (sel < 60) return 32'sh0;
    if (sel < 70) return -int'($urandom_range(65536)) - 1;
    if (sel < 80) return 32'sh7fff_ffff;
    return $urandom;
  endfunction

  function automatic logic signed [17:0] pick_priority();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return 18'($urandom_range(PRIO_FULL));
    if (sel < 50) begin
      case ($urandom_range(2))
        0: return 18'sd0;
        1: return 18'sd32768;
        default: return 18'(PRIO_FULL);
      endcase
    end
    if (sel < 70) return 18'($urandom);
    if (sel < 85) return 18'(PRIO_FULL + int'($urandom_range(65535, 1)));
    return 18'(-int'($urandom_range(131072, 1)));
  endfunction

  // Random transaction: mostly well-formed table traffic with noise in the
  // fields that the operation ignores.
  function automatic goal_cmd_t random_goal_cmd();
    goal_cmd_t c;
    int        sel;
    int        slot;
    int        g;
    c.goal_index = 3'($urandom);
    c.dim_index = 2'($urandom);
    c.target_value = $urandom;
    c.tolerance_value = $urandom;
    c.dim_count = 3'($urandom);
    c.priority_value = 18'($urandom);
    c.measured_value = $urandom;
    sel = $urandom_range(99);
    if (sel < 22) begin
      c.op = OP_WRITE_DIM;
      if ($urandom_range(99) < 60)
        c.goal_index = 3'($urandom_range(goal_total < GPA_GOAL_SLOTS ? goal_total
                                                                    : GPA_GOAL_SLOTS - 1));
      c.target_value = pick_value();
      c.tolerance_value = pick_tolerance();
    end else if (sel < 27) begin
      c.op = OP_APPEND;
      c.dim_count = ($urandom_range(99) < 85) ? 3'($urandom_range(GPA_MAX_DIMS))
                                              : 3'($urandom_range(7, GPA_MAX_DIMS + 1));
    end else if (sel < 39) begin
      c.op = OP_SET_PRIO;
      c.priority_value = pick_priority();
    end else if (sel < 45) begin
      c.op = OP_SELECT;
    end else if (sel < 67) begin
      c.op = OP_WRITE_MEAS;
      c.measured_value = pick_value();
      if (goal_total > 0 && $urandom_range(99) < 60) begin
        g = $urandom_range(goal_total - 1);
        slot = g * GPA_MAX_DIMS + c.dim_index;
        if (entry_written[slot])
          c.measured_value = 32'(goal_target[slot]) + int'($urandom_range(131072)) - 65536;
      end
    end else if (sel < 95) begin
      c.op = OP_ARBITRATE;
      // Never let an arbitration read an entry that was never written.
      if (find_unwritten(slot)) begin
        c.op = OP_WRITE_DIM;
        c.goal_index = 3'(slot / GPA_MAX_DIMS);
        c.dim_index = 2'(slot % GPA_MAX_DIMS);
        c.target_value = pick_value();
        c.tolerance_value = pick_tolerance();
      end
    end else begin
      c.op = $urandom_range(1) ? OP_RESERVED_LO : OP_RESERVED_HI;
    end
    return c;
  endfunction

  // Offer one transaction, hold it until accepted, then record its result.
  task automatic send_cmd(input goal_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    op_i              <= c.op;
    goal_index_i      <= c.goal_index;
    dim_index_i       <= c.dim_index;
    target_value_i    <= c.target_value;
    tolerance_value_i <= c.tolerance_value;
    dim_count_i       <= c.dim_count;
    priority_value_i  <= c.priority_value;
    measured_value_i  <= c.measured_value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_status.push_back(apply_goal_cmd(c));
  endtask

  // Directed transaction; the value argument serves as target and measurement.
  task automatic send_fields(input logic [2:0] op, input logic [2:0] gi,
                             input logic [1:0] di, input logic signed [31:0] value,
                             input logic signed [31:0] tol, input logic [2:0] dc,
                             input logic signed [17:0] prio);
    goal_cmd_t c;
    c = '{op, gi, di, value, tol, dc, prio, value};
    send_cmd(c);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  // Edge cases of every operation on a fresh table.
  task automatic test_directed();
    send_idle_pct = 23;
    recv_stall_pct = 79;
    send_fields(OP_ARBITRATE, 3'd0, 2'd0, 0, 0, 3'd0, 0);
    send_fields(OP_RESERVED_LO, 3'd7, 2'd3, -1, -1, 3'd7, -1);
    send_fields(OP_RESERVED_HI, 3'd0, 2'd0, 0, 0, 3'd0, 0);
    send_fields(OP_SET_PRIO, 3'd0, 2'd0, 0, 0, 3'd0, 100);
    send_fields(OP_SELECT, 3'd0, 2'd0, 0, 0, 3'd0, 0);
    send_fields(OP_APPEND, 3'd0, 2'd0, 0, 0, 3'd5, 0);
    send_fields(OP_APPEND, 3'd0, 2'd0, 0, 0, 3'd7, 0);
    // Goal 0: extreme target with widest tolerance, and a negative tolerance.
    send_fields(OP_WRITE_DIM, 3'd0, 2'd0, 32'sh8000_0000, 32'sh7fff_ffff, 3'd0, 0);
    send_fields(OP_WRITE_DIM, 3'd0, 2'd1, 32'sh7fff_ffff, 32'sh8000_0000, 3'd0, 0);
    send_fields(OP_APPEND, 3'd5, 2'd0, 0, 0, 3'd2, 0);
    send_fields(OP_APPEND, 3'd0, 2'd0, 0, 0, 3'd0, 0);
    // Largest possible error overflows any tolerance.
    send_fields(OP_WRITE_MEAS, 3'd0, 2'd0, 32'sh7fff_ffff, 0, 3'd0, 0);
    send_fields(OP_WRITE_MEAS, 3'd0, 2'd1, 32'sh7fff_ffff, 0, 3'd0, 0);
    send_fields(OP_ARBITRATE, 3'd0, 2'd0, 0, 0, 3'd0, 0);
    send_fields(OP_WRITE_MEAS, 3'd0, 2'd0, 32'sh8000_0000, 0, 3'd0, 0);
    send_fields(OP_ARBITRATE, 3'd0, 2'd0, 0, 0, 3'd0, 0);
    // With the negative tolerance gone every goal is met.
    send_fields(OP_WRITE_DIM, 3'd0, 2'd1, 32'sh7fff_ffff, 0, 3'd0, 0);
    send_fields(OP_ARBITRATE, 3'd0, 2'd0, 0, 0, 3'd0, 0);
    // Priority clamping at both ends.
    send_fields(OP_SET_PRIO, 3'd1, 2'd0, 0, 0, 3'd0, -5);
    send_fields(OP_SET_PRIO, 3'd0, 2'd0, 0, 0, 3'd0, 131071);
    send_fields(OP_SET_PRIO, 3'd0, 2'd0, 0, 0, 3'd0, -131072);
    // Reselecting the active goal still counts a switch.
    send_fields(OP_SELECT, 3'd1, 2'd0, 0, 0, 3'd0, 0);
    send_fields(OP_SELECT, 3'd1, 2'd0, 0, 0, 3'd0, 0);
    send_fields(OP_WRITE_DIM, 3'd7, 2'd3, 32'sh7fff_ffff, 32'sh8000_0000, 3'd0, 0);
    send_fields(OP_WRITE_MEAS, 3'd7, 2'd3, 32'sh8000_0000, 0, 3'd0, 0);
    send_fields(OP_APPEND, 3'd0, 2'd0, 0, 0, 3'd4, 0);
    send_fields(OP_SELECT, 3'd7, 2'd0, 0, 0, 3'd0, 0);
  endtask

  // Random traffic under one idling pattern; reserved opcodes are not counted.
  task automatic test_random_mix(input int sender_pct, input int receiver_pct,
                                 input int count);
    goal_cmd_t c;
    int        done;
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    done = 0;
    while (done < count) begin
      c = random_goal_cmd();
      send_cmd(c);
      if (c.op != OP_RESERVED_LO && c.op != OP_RESERVED_HI) done++;
    end
  endtask

  // Fill the table and check that further appends are refused.
  task automatic test_full_table();
    goal_cmd_t c;
    while (goal_total < GPA_GOAL_SLOTS) begin
      c = random_goal_cmd();
      c.op = OP_APPEND;
      c.dim_count = 3'($urandom_range(GPA_MAX_DIMS));
      send_cmd(c);
    end
    c = random_goal_cmd();
    c.op = OP_APPEND;
    c.dim_count = 3'($urandom_range(GPA_MAX_DIMS));
    send_cmd(c);
    repeat (20) send_cmd(random_goal_cmd());
  endtask

  // Receiver holds off while the sender keeps offering, then a full drain.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles_req = HOLD_CYCLES;
    repeat (20) send_cmd(random_goal_cmd());
    wait_drained();
    repeat (20) send_cmd(random_goal_cmd());
  endtask

  // Receiver stall: random, or a long hold counted here on request.
  always @(posedge clk_i) begin
    if (hold_cycles_req != 0) begin
      hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every accepted result with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    goal_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        $display("%0t: result with no transaction outstanding", $time);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("status", want.status, status_o);
        check_field("lead_goal", want.lead_goal, lead_goal_o);
        check_field("has_active", want.has_active, has_active_o);
        check_field("switch_count", want.switch_count, switch_count_o);
        check_field("achieved_mask", want.achieved_mask, achieved_mask_o);
        check_field("goal_count", want.goal_count, goal_count_o);
        check_field("reference_update", want.reference_update, reference_update_o);
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix(23, 79, 170);
    test_random_mix(79, 23, 170);
    test_random_mix(0, 0, 170);
    test_full_table();
    test_output_hold();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ goal_priority_arbiter.f @@
sv/gpa_pkg.sv
sv/gpa_goal_mem.sv
sv/gpa_tol_check.sv
sv/goal_priority_arbiter.sv
tb/tb_goal_priority_arbiter.sv
